FILE: hw/rtl/bbs_pkg.sv
// Shared types and constants for the buzzer beep sequencer.
package bbs_pkg;

    // Item kinds carried on the input tuser lane.
    typedef enum logic [1:0] {
        KIND_FAST   = 2'd0,
        KIND_SECOND = 2'd1,
        KIND_START  = 2'd2
    } kind_t;

    // Timing constants of the beep pattern.
    localparam logic [3:0] PRESCALE_LIMIT = 4'd10;
    localparam logic [9:0] TONE_TICKS     = 10'd500;
    localparam logic [9:0] PERIOD_TICKS   = 10'd1000;
    localparam logic [2:0] REPEAT_GAP     = 3'd2;

    // Field widths of one request.
    localparam int BEEP_W   = 8;
    localparam int REPEAT_W = 7;

    // One result: pin level, pin drive and busy flag.
    typedef struct packed {
        logic busy;
        logic drive;
        logic level;
    } result_t;

endpackage

FILE: hw/rtl/bbs_core.sv
// Sequencer state and the combinational update applied for each request.
module bbs_core
    import bbs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  kind_t               kind,
    input  logic [BEEP_W-1:0]   beep_count,
    input  logic [REPEAT_W-1:0] repeat_count,
    input  logic                buzzer_enable,
    output result_t             result_next
);

    logic [3:0]          prescale_reg, prescale_next;
    logic [9:0]          period_reg, period_next;
    logic [BEEP_W-1:0]   done_reg, done_next;
    logic [BEEP_W-1:0]   target_reg, target_next;
    logic [REPEAT_W-1:0] repeats_reg, repeats_next;
    logic [1:0]          gap_reg, gap_next;
    logic                running_reg, running_next;
    logic                level_reg, level_next;
    logic                drive_reg, drive_next;
    logic [2:0]          gap_inc;

    // Next state for one request.
    always_comb
    begin
        prescale_next = prescale_reg;
        period_next   = period_reg;
        done_next     = done_reg;
        target_next   = target_reg;
        repeats_next  = repeats_reg;
        gap_next      = gap_reg;
        running_next  = running_reg;
        level_next    = level_reg;
        drive_next    = drive_reg;
        gap_inc       = {1'b0, gap_reg} + 3'd1;

        case (kind)
            KIND_FAST:
            begin
                if (running_reg)
                begin
                    if (prescale_reg > PRESCALE_LIMIT)
                    begin
                        // Tone phase toggles the drive; silent phase drops the level.
                        if (period_reg < TONE_TICKS)
                            drive_next = ~drive_reg;
                        else
                            level_next = 1'b0;
                        if (period_reg > PERIOD_TICKS)
                        begin
                            if (done_reg == target_reg)
                            begin
                                // Last beep of the burst has ended.
                                period_next   = 10'd0;
                                running_next  = 1'b0;
                                level_next    = 1'b0;
                                prescale_next = 4'd0;
                                done_next     = '0;
                                if (repeats_reg != '0)
                                begin
                                    repeats_next = repeats_reg - REPEAT_W'(1);
                                    gap_next     = 2'd1;
                                end
                            end
                            else
                            begin
                                // A new beep period begins.
                                level_next    = 1'b1;
                                done_next     = done_reg + BEEP_W'(1);
                                period_next   = 10'd1;
                                prescale_next = 4'd1;
                            end
                        end
                        else
                        begin
                            period_next   = period_reg + 10'd1;
                            prescale_next = 4'd1;
                        end
                    end
                    else
                    begin
                        prescale_next = prescale_reg + 4'd1;
                    end
                end
            end
            KIND_SECOND:
            begin
                // Gap between bursts, counted in second ticks.
                if (gap_reg != 2'd0)
                begin
                    if (gap_inc > REPEAT_GAP)
                    begin
                        gap_next = 2'd0;
                        if (buzzer_enable)
                        begin
                            level_next    = 1'b1;
                            running_next  = 1'b1;
                            prescale_next = 4'd0;
                            done_next     = '0;
                        end
                    end
                    else
                    begin
                        gap_next = gap_inc[1:0];
                    end
                end
            end
            KIND_START:
            begin
                if (buzzer_enable)
                begin
                    repeats_next  = repeat_count;
                    target_next   = beep_count - BEEP_W'(1);
                    level_next    = 1'b1;
                    running_next  = 1'b1;
                    prescale_next = 4'd0;
                    done_next     = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result_next = '{busy: running_next, drive: drive_next, level: level_next};

    // State registers, updated once per request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            period_reg   <= '0;
            done_reg     <= '0;
            target_reg   <= '0;
            repeats_reg  <= '0;
            gap_reg      <= '0;
            running_reg  <= 1'b0;
            level_reg    <= 1'b0;
            drive_reg    <= 1'b1;
        end
        else if (step)
        begin
            prescale_reg <= prescale_next;
            period_reg   <= period_next;
            done_reg     <= done_next;
            target_reg   <= target_next;
            repeats_reg  <= repeats_next;
            gap_reg      <= gap_next;
            running_reg  <= running_next;
            level_reg    <= level_next;
            drive_reg    <= drive_next;
        end
    end

    // A fast tick while idle leaves the pattern state untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && kind == KIND_FAST && !running_reg |=>
            $stable(period_reg) && $stable(drive_reg) && $stable(level_reg)
            && !running_reg)
        else $error("fast tick changed idle sequencer");

    // The prescaler never runs past its wrap point.
    assert property (@(posedge clk) disable iff (!rst_n)
        prescale_reg <= PRESCALE_LIMIT + 4'd1)
        else $error("prescaler out of range");

    // A start while disabled is dropped entirely.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && kind == KIND_START && !buzzer_enable |=>
            $stable(target_reg) && $stable(repeats_reg) && $stable(running_reg))
        else $error("start accepted while disabled");

    // The beep counter never passes the burst target while sounding.
    assert property (@(posedge clk) disable iff (!rst_n)
        running_reg && $stable(target_reg) && $past(running_reg) |->
            done_reg <= target_reg || $stable(done_reg))
        else $error("beep counter ran past target");

endmodule

FILE: hw/rtl/buzzer_beep_sequencer.sv
// Each request is held in the input register, and its result is presented once the held
// request moves from the input register into the free result register.
// Throughput: one request per cycle while m_tready is high; s_tready follows
// m_tready in the same cycle when both registers are full.
// Reset (rst_n low, asynchronous): sequencer idle, pin level low, drive high,
// buzzer enabled, no request or result held.
module buzzer_beep_sequencer
    import bbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // beep_count [7:0], repeat_count [14:8], zero [15]
    input  logic [1:0]  s_tuser,   // kind [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // pin_level [0], pin_drive [1], busy_res [2], zero [7:3]
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    logic                in_valid_reg;
    kind_t               in_kind_reg;
    logic [BEEP_W-1:0]   in_beep_reg;
    logic [REPEAT_W-1:0] in_repeat_reg;
    logic                out_valid_reg;
    result_t             out_res_reg;
    result_t             result_next;
    logic                enable_reg;
    logic                advance;
    logic                in_take;

    // Handshake: the held request moves on when the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            enable_reg    <= 1'b1;
        end
        else
        begin
            in_valid_reg  <= in_take || (in_valid_reg && !advance);
            out_valid_reg <= advance || (out_valid_reg && !m_tready);
            if (cfg_we)
                enable_reg <= cfg_wdata;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_kind_reg   <= kind_t'(s_tuser);
            in_beep_reg   <= s_tdata[7:0];
            in_repeat_reg <= s_tdata[14:8];
        end
        if (advance)
            out_res_reg <= result_next;
    end

    // Pattern state and its update.
    bbs_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .kind          (in_kind_reg),
        .beep_count    (in_beep_reg),
        .repeat_count  (in_repeat_reg),
        .buzzer_enable (enable_reg),
        .result_next   (result_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_res_reg.busy, out_res_reg.drive, out_res_reg.level};

endmodule

FILE: sim/buzzer_result_checker.sv
// Checker for the buzzer beep sequencer: predicts each result and compares it.
`timescale 1ns / 100ps

module buzzer_result_checker
    import bbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // beep_count [7:0], repeat_count [14:8], zero [15]
    input  logic [1:0]  s_tuser,   // kind [1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // pin_level [0], pin_drive [1], busy_res [2], zero [7:3]
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    output int          fail_count,
    output int          pending
);

    // Predicted sequencer state.
    logic       enabled;
    logic [3:0] tick_divider;
    logic [9:0] period_pos;
    logic [7:0] beeps_sounded;
    logic [7:0] last_beep;
    logic [6:0] bursts_left;
    logic [1:0] pause_secs;
    logic       sounding;
    logic       level_bit;
    logic       drive_bit;

    // Pin states expected from the block, oldest first.
    result_t expected_pins[$];

    task report_failure(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count = fail_count + 1;
    endtask

    function void clear_sequencer();
        enabled       = 1'b1;
        tick_divider  = '0;
        period_pos    = '0;
        beeps_sounded = '0;
        last_beep     = '0;
        bursts_left   = '0;
        pause_secs    = '0;
        sounding      = 1'b0;
        level_bit     = 1'b0;
        drive_bit     = 1'b1;
    endfunction

    // Load a burst and raise the pin; the period position is left alone.
    function void load_burst(input logic [7:0] target, input logic [6:0] repeats);
        bursts_left   = repeats;
        last_beep     = target;
        level_bit     = 1'b1;
        sounding      = 1'b1;
        tick_divider  = '0;
        beeps_sounded = '0;
    endfunction

    // One fast tick: prescale, toggle the tone, and close beeps and bursts.
    function void step_fast_tick();
        if (!sounding)
            return;
        if (tick_divider > PRESCALE_LIMIT)
        begin
            if (period_pos < TONE_TICKS)
                drive_bit = ~drive_bit;
            else
                level_bit = 1'b0;
            if (period_pos > PERIOD_TICKS)
            begin
                period_pos = '0;
                level_bit  = 1'b1;
                if (beeps_sounded == last_beep)
                begin
                    sounding      = 1'b0;
                    level_bit     = 1'b0;
                    tick_divider  = '0;
                    beeps_sounded = '0;
                    if (bursts_left != 0)
                    begin
                        bursts_left = bursts_left - 7'd1;
                        pause_secs  = 2'd1;
                    end
                    return;
                end
                beeps_sounded = beeps_sounded + 8'd1;
            end
            period_pos   = period_pos + 10'd1;
            tick_divider = '0;
        end
        tick_divider = tick_divider + 4'd1;
    endfunction

    // One second tick: count the pause between bursts and restart when it ends.
    function void step_second_tick();
        logic [2:0] next_secs;
        if (pause_secs == 0)
            return;
        next_secs = {1'b0, pause_secs} + 3'd1;
        if (next_secs > REPEAT_GAP)
        begin
            if (enabled)
                load_burst(last_beep, bursts_left);
            pause_secs = '0;
        end
        else
        begin
            pause_secs = next_secs[1:0];
        end
    endfunction

    function result_t apply_request(input logic [1:0] kind, input logic [7:0] beeps,
                                    input logic [6:0] repeats);
        result_t pins;
        case (kind)
            KIND_FAST:   step_fast_tick();
            KIND_SECOND: step_second_tick();
            KIND_START:
            begin
                if (enabled)
                    load_burst(beeps - 8'd1, repeats);
            end
            default:     ;
        endcase
        pins.level = level_bit;
        pins.drive = drive_bit;
        pins.busy  = sounding;
        return pins;
    endfunction

    // Results are checked before new requests are predicted in the same cycle.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            clear_sequencer();
            expected_pins.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_pins.size() == 0)
                begin
                    report_failure($sformatf("result 0x%02h with no request pending",
                                             m_tdata));
                end
                else
                begin
                    want = expected_pins.pop_front();
                    if (m_tdata[0] !== want.level)
                        report_failure($sformatf("pin_level %b, expected %b",
                                                 m_tdata[0], want.level));
                    if (m_tdata[1] !== want.drive)
                        report_failure($sformatf("pin_drive %b, expected %b",
                                                 m_tdata[1], want.drive));
                    if (m_tdata[2] !== want.busy)
                        report_failure($sformatf("busy_res %b, expected %b",
                                                 m_tdata[2], want.busy));
                end
            end
            if (cfg_we)
                enabled = cfg_wdata;
            if (s_tvalid && s_tready)
                expected_pins.push_back(apply_request(s_tuser, s_tdata[7:0],
                                                      s_tdata[14:8]));
            pending = expected_pins.size();
        end
    end

endmodule

FILE: sim/tb_buzzer_beep_sequencer.sv
// Testbench top for the buzzer beep sequencer: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_buzzer_beep_sequencer;
    import bbs_pkg::*;

    // Kind code that the block must treat as a no-op.
    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400_000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // beep_count [7:0], repeat_count [14:8], zero [15]
    logic [1:0]  s_tuser;   // kind [1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // pin_level [0], pin_drive [1], busy_res [2], zero [7:3]
    logic        cfg_we;
    logic        cfg_wdata;
    int          fail_count;
    int          pending;
    logic        calm;
    int unsigned cycles = 0;

    buzzer_beep_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    buzzer_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Mostly no pause, sometimes a short one, rarely a long one; never a pause while calm is set.
    function int unsigned idle_span();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task send_request(input logic [1:0] kind, input logic [7:0] beeps,
                      input logic [6:0] repeats);
        int unsigned gap;
        gap = idle_span();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, repeats, beeps};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the sender until every expected result has come back.
    task drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task write_enable(input logic value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // A run of fast ticks with random payload, optionally sprinkled with second ticks.
    task tick_run(input int count, input int second_odds);
        for (int i = 0; i < count; i++)
        begin
            if (second_odds != 0 && $urandom_range(1, second_odds) == 1)
                send_request(KIND_SECOND, 8'($urandom_range(0, 255)),
                             7'($urandom_range(0, 127)));
            else
                send_request(KIND_FAST, 8'($urandom_range(0, 255)),
                             7'($urandom_range(0, 127)));
        end
    endtask

    // Result side: ready stretches broken by stalls of random length.
    initial
    begin
        int unsigned stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = idle_span();
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int unsigned roll;
        int          start_odds;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_FAST;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        calm      = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: idle no-ops, wrapped beep count, restart while running.
        send_request(KIND_RESERVED, 8'hFF, 7'h7F);
        send_request(KIND_FAST, 8'h00, 7'h00);
        send_request(KIND_SECOND, 8'h00, 7'h00);
        send_request(KIND_START, 8'h00, 7'h7F);
        tick_run(12, 0);
        send_request(KIND_RESERVED, 8'h00, 7'h00);
        send_request(KIND_START, 8'hFF, 7'h00);
        send_request(KIND_SECOND, 8'hFF, 7'h7F);
        tick_run(3, 0);

        // Directed: starts are dropped while the buzzer is disabled.
        write_enable(1'b0);
        send_request(KIND_START, 8'h01, 7'h05);
        send_request(KIND_FAST, 8'hFF, 7'h7F);
        send_request(KIND_SECOND, 8'h01, 7'h01);
        write_enable(1'b1);

        // Random mix, alternating frequent and rare starts; two chunks run disabled, one calm.
        for (int chunk = 0; chunk < 7; chunk++)
        begin
            write_enable(!(chunk == 1 || chunk == 5));
            calm = (chunk == 3);
            start_odds = chunk[0] ? 3 : 40;
            for (int i = 0; i < 100; i++)
            begin
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                roll = $urandom_range(0, 19);
                if ($urandom_range(1, start_odds) == 1)
                    send_request(KIND_START, 8'($urandom_range(0, 255)),
                                 7'($urandom_range(0, 127)));
                else if (roll == 0)
                    send_request(KIND_RESERVED, 8'($urandom_range(0, 255)),
                                 7'($urandom_range(0, 127)));
                else if (roll < 4)
                    send_request(KIND_SECOND, 8'($urandom_range(0, 255)),
                                 7'($urandom_range(0, 127)));
                else
                    send_request(KIND_FAST, 8'($urandom_range(0, 255)),
                                 7'($urandom_range(0, 127)));
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/bbs_pkg.sv
hw/rtl/bbs_core.sv
hw/rtl/buzzer_beep_sequencer.sv
sim/buzzer_result_checker.sv
sim/tb_buzzer_beep_sequencer.sv
